/* sv/cf3_pkg.sv */
// package for the 3x3 correlation filter: sizes, register indexes, job type
// and coefficient selection; no dependencies
`timescale 1ns / 1ps
package cf3_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int MinSize   = 10;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int SizeW     = 11;
    localparam int CoefRowW  = 24;
    localparam int Taps      = 9;
    localparam int AccW      = 21;
    localparam int MagW      = 20;
    localparam int DsumW     = 12;
    localparam int DenW      = 11;
    localparam int CfgAddrW  = 3;

    // register indexes of the configuration port
    localparam logic [CfgAddrW-1:0] REG_COEF_TOP    = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_COEF_MID    = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_COEF_BOTTOM = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_WIDTH       = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_HEIGHT      = 3'd4;

    localparam logic [7:0] PixMax = 8'hFF;

    // one window to be filtered, row-major taps
    typedef struct packed {
        logic [Taps-1:0][7:0] win;
        logic [RowW-1:0]      row;
        logic [ColW-1:0]      col;
        logic                 last;
    } job_t;

    typedef struct packed {
        logic [CoefRowW-1:0] top;
        logic [CoefRowW-1:0] mid;
        logic [CoefRowW-1:0] bot;
    } coef_t;

    // signed coefficient of tap k (row k/3, column k%3)
    function automatic logic signed [7:0] coef_pick(coef_t cf, logic [3:0] k);
        logic [7:0] b;
        begin
            b = 8'd0;
            unique case (k)
                4'd0: b = cf.top[7:0];
                4'd1: b = cf.top[15:8];
                4'd2: b = cf.top[23:16];
                4'd3: b = cf.mid[7:0];
                4'd4: b = cf.mid[15:8];
                4'd5: b = cf.mid[23:16];
                4'd6: b = cf.bot[7:0];
                4'd7: b = cf.bot[15:8];
                4'd8: b = cf.bot[23:16];
                default: b = 8'd0;
            endcase
            return $signed(b);
        end
    endfunction

endpackage

/* sv/cf3_ram.sv */
// generic single write, single read memory with registered read
// no dependencies
`timescale 1ns / 1ps
module cf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/cf3_front.sv */
// front end: accepts pixels, keeps line stores, window and counters,
// queues a job for each interior pixel; uses cf3_pkg and cf3_ram
`timescale 1ns / 1ps
module cf3_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // pixel
    input  logic                         s_tuser,   // frame_start
    input  logic [cf3_pkg::SizeW-1:0]    width,
    input  logic [cf3_pkg::SizeW-1:0]    height,
    input  logic                         q_full,
    output logic                         q_push,
    output cf3_pkg::job_t                q_data
);
    import cf3_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_WRITE = 1'b1;

    logic            state_reg;
    logic [ColW-1:0] col_reg;
    logic [RowW-1:0] row_reg;
    logic [ColW-1:0] c_cur_reg;
    logic [RowW-1:0] r_cur_reg;
    logic [7:0]      px_reg;
    logic [7:0]      wc_reg [6];
    logic [ColW-1:0] col_in;
    logic [RowW-1:0] row_in;
    logic [7:0]      top;
    logic [7:0]      mid;
    logic            accept;
    logic            emit;
    logic [ColW-1:0] raddr;

    assign s_tready = (state_reg == ST_IDLE) && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign col_in   = s_tuser ? '0 : col_reg;
    assign row_in   = s_tuser ? '0 : row_reg;
    assign raddr    = col_in;

    // line stores
    cf3_ram #(.WIDTH(8), .DEPTH(MaxWidth)) u_prev (
        .clk(clk), .we(state_reg == ST_WRITE), .waddr(c_cur_reg), .wdata(px_reg),
        .raddr(raddr), .rdata(mid)
    );
    cf3_ram #(.WIDTH(8), .DEPTH(MaxWidth)) u_prev2 (
        .clk(clk), .we(state_reg == ST_WRITE), .waddr(c_cur_reg), .wdata(mid),
        .raddr(raddr), .rdata(top)
    );

    // interior test and job assembly
    assign emit = (r_cur_reg >= RowW'(2)) && (c_cur_reg >= ColW'(2))
                  && ({1'b0, r_cur_reg} < height) && ({1'b0, c_cur_reg} < width);
    assign q_push = (state_reg == ST_WRITE) && emit;

    always_comb
    begin
        q_data.win[0] = wc_reg[0];
        q_data.win[1] = wc_reg[3];
        q_data.win[2] = top;
        q_data.win[3] = wc_reg[1];
        q_data.win[4] = wc_reg[4];
        q_data.win[5] = mid;
        q_data.win[6] = wc_reg[2];
        q_data.win[7] = wc_reg[5];
        q_data.win[8] = px_reg;
        q_data.row    = r_cur_reg - RowW'(1);
        q_data.col    = c_cur_reg - ColW'(1);
        q_data.last   = ({1'b0, r_cur_reg} == height - SizeW'(1))
                        && ({1'b0, c_cur_reg} == width - SizeW'(1));
    end

    // sequencing, window shift and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            c_cur_reg <= '0;
            r_cur_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                wc_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        c_cur_reg <= col_in;
                        r_cur_reg <= row_in;
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    wc_reg[0] <= wc_reg[3];
                    wc_reg[1] <= wc_reg[4];
                    wc_reg[2] <= wc_reg[5];
                    wc_reg[3] <= top;
                    wc_reg[4] <= mid;
                    wc_reg[5] <= px_reg;
                    if ({1'b0, c_cur_reg} + SizeW'(1) >= width)
                    begin
                        col_reg <= '0;
                        row_reg <= ({1'b0, r_cur_reg} + SizeW'(1) >= height)
                                   ? '0 : r_cur_reg + RowW'(1);
                    end
                    else
                    begin
                        col_reg <= c_cur_reg + ColW'(1);
                        row_reg <= r_cur_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // pixel holding register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= s_tdata;
        end
    end

endmodule

/* sv/cf3_queue.sv */
// two-entry job queue between front and back end
// uses cf3_pkg
`timescale 1ns / 1ps
module cf3_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cf3_pkg::job_t push_data,
    input  logic          pop,
    output cf3_pkg::job_t pop_data,
    output logic          full,
    output logic          empty
);
    import cf3_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

/* sv/cf3_back.sv */
// back end: serial multiply-accumulate over nine taps, restoring divide by
// the coefficient sum, clamp and output register; uses cf3_pkg
`timescale 1ns / 1ps
module cf3_back (
    input  logic              clk,
    input  logic              rst_n,
    input  cf3_pkg::coef_t    coef,
    input  logic              q_empty,
    output logic              q_pop,
    input  cf3_pkg::job_t     q_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // out_pixel, out_row, out_col, zero fill
    output logic              m_tlast    // last_of_frame
);
    import cf3_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]              state_reg;
    job_t                    job_reg;
    logic [4:0]              k_reg;
    logic signed [AccW-1:0]  acc_reg;
    logic signed [DsumW-1:0] dsum_reg;
    logic [MagW-1:0]         num_reg;
    logic [MagW-1:0]         quo_reg;
    logic [DenW-1:0]         den_reg;
    logic [DenW-1:0]         rem_reg;
    logic                    neg_reg;
    logic                    valid_reg;
    logic [7:0]              pix_reg;
    logic [RowW-1:0]         row_reg;
    logic [ColW-1:0]         col_reg;
    logic                    last_reg;
    logic signed [7:0]       cf;
    logic signed [16:0]      prod;
    logic [DenW:0]           trial;
    logic                    fits;
    logic signed [DsumW-1:0] dsum_nz;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty && !valid_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, col_reg, row_reg, pix_reg};
    assign m_tlast  = last_reg;

    // one tap product per cycle
    assign cf    = coef_pick(coef, k_reg[3:0]);
    assign prod  = $signed({1'b0, job_reg.win[k_reg[3:0]]}) * $signed({{1{cf[7]}}, cf});
    assign trial = {rem_reg, num_reg[MagW-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign dsum_nz = (dsum_reg == '0) ? DsumW'(1) : dsum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            if (valid_reg && m_tready)
            begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    k_reg <= k_reg + 5'd1;
                    if (k_reg == 5'(Taps - 1))
                    begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    k_reg     <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    k_reg <= k_reg + 5'd1;
                    if (k_reg == 5'(MagW - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg  <= q_data;
                acc_reg  <= '0;
                dsum_reg <= '0;
            end
            ST_MAC:
            begin
                acc_reg  <= acc_reg + AccW'(prod);
                dsum_reg <= dsum_reg + DsumW'(cf);
            end
            ST_PREP:
            begin
                num_reg <= acc_reg[AccW-1] ? MagW'(-acc_reg) : MagW'(acc_reg);
                den_reg <= dsum_nz[DsumW-1] ? DenW'(-dsum_nz) : DenW'(dsum_nz);
                neg_reg <= acc_reg[AccW-1] ^ dsum_nz[DsumW-1];
                rem_reg <= '0;
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                num_reg <= {num_reg[MagW-2:0], 1'b0};
                rem_reg <= fits ? DenW'(trial - {1'b0, den_reg}) : trial[DenW-1:0];
                quo_reg <= {quo_reg[MagW-2:0], fits};
            end
            ST_FIN:
            begin
                if (neg_reg)
                begin
                    pix_reg <= 8'd0;
                end
                else if (quo_reg > MagW'(PixMax))
                begin
                    pix_reg <= PixMax;
                end
                else
                begin
                    pix_reg <= quo_reg[7:0];
                end
                row_reg  <= job_reg.row;
                col_reg  <= job_reg.col;
                last_reg <= job_reg.last;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* sv/correlation_3x3_filter_u8.sv */
// path from an input beat to m_tvalid: front end, queue hand-off, back end (9-tap
// serial multiply-accumulate, setup, 20-step divide, clamp)
// flow: the front end takes no new pixel while it writes the last one or while the
// queue is full; the back end takes no new job until the last result is taken,
// with a 2-job queue between
// reset (rst_n low, asynchronous): counters, window and queue cleared,
// coefficients identity, size 1024 x 1024; line stores are not cleared
`timescale 1ns / 1ps
module correlation_3x3_filter_u8 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_pixel[7:0], out_row[17:8], out_col[27:18]
    output logic        m_tlast,   // last_of_frame
    input  logic        cfg_we,
    input  logic [cf3_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [cf3_pkg::CoefRowW-1:0] cfg_data
);
    import cf3_pkg::*;

    coef_t            coef_reg;
    logic [SizeW-1:0] width_reg;
    logic [SizeW-1:0] height_reg;
    logic [SizeW-1:0] width_sat;
    logic [SizeW-1:0] height_sat;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    job_t             q_in;
    job_t             q_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.top <= '0;
            coef_reg.mid <= CoefRowW'(256);
            coef_reg.bot <= '0;
            width_reg    <= SizeW'(MaxWidth);
            height_reg   <= SizeW'(MaxHeight);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_COEF_TOP:    coef_reg.top <= cfg_data;
                REG_COEF_MID:    coef_reg.mid <= cfg_data;
                REG_COEF_BOTTOM: coef_reg.bot <= cfg_data;
                REG_WIDTH:       width_reg    <= cfg_data[SizeW-1:0];
                REG_HEIGHT:      height_reg   <= cfg_data[SizeW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // size saturation
    assign width_sat  = (width_reg < SizeW'(MinSize)) ? SizeW'(MinSize)
                      : (width_reg > SizeW'(MaxWidth)) ? SizeW'(MaxWidth) : width_reg;
    assign height_sat = (height_reg < SizeW'(MinSize)) ? SizeW'(MinSize)
                      : (height_reg > SizeW'(MaxHeight)) ? SizeW'(MaxHeight) : height_reg;

    cf3_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .width(width_sat), .height(height_sat),
        .q_full(q_full), .q_push(q_push), .q_data(q_in)
    );

    cf3_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(q_in), .pop(q_pop), .pop_data(q_out),
        .full(q_full), .empty(q_empty)
    );

    cf3_back u_back (
        .clk(clk), .rst_n(rst_n), .coef(coef_reg),
        .q_empty(q_empty), .q_pop(q_pop), .q_data(q_out),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

`ifndef NO_ASSERTIONS
    // front never writes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("job pushed into full queue");
    // back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("job popped from empty queue");
    // an accepted pixel blocks the input for the following cycle
    assert property (@(posedge clk) disable iff (!rst_n) (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready while line store write pending");
    // results are never on row 0 or column 0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:8] != 10'd0) && (m_tdata[27:18] != 10'd0))
        else $error("border position emitted");
`endif

endmodule
